// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// expression never true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`endif

// ===== rtl/rgbhsv_pkg.sv =====
// shared types and constants of the rgb to hsv converter
`default_nettype none
package rgbhsv_pkg;

   localparam int QUO_BITS  = 7;
   localparam int NUM_BITS  = 15;
   localparam int DSH_BITS  = 14;
   localparam int NUM_CELLS = QUO_BITS;

   localparam logic [1:0] SECT_NONE  = 2'd0;
   localparam logic [1:0] SECT_RED   = 2'd1;
   localparam logic [1:0] SECT_GREEN = 2'd2;
   localparam logic [1:0] SECT_BLUE  = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] saturation;
      logic [6:0] brightness;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [NUM_BITS-1:0] h_rem;
      logic [DSH_BITS-1:0] h_dsh;
      logic [QUO_BITS-1:0] h_quo;
      logic [NUM_BITS-1:0] s_rem;
      logic [DSH_BITS-1:0] s_dsh;
      logic [QUO_BITS-1:0] s_quo;
      logic                neg;
      logic [1:0]          sector;
      logic                hue_zero;
      logic                sat_zero;
      logic [7:0]          top;
   } cell_type;

endpackage
`default_nettype wire

// ===== rtl/rgbhsv_cell.sv =====
// one divider cell: one quotient bit of the hue and saturation divisions
`default_nettype none
module rgbhsv_cell import rgbhsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_d,
   output cell_type cell_q
);

   cell_type cell_ff, cell_in;
   logic     h_ge, s_ge;

   always_comb begin
      cell_in = cell_d;
      h_ge = cell_d.h_rem >= {1'b0, cell_d.h_dsh};
      s_ge = cell_d.s_rem >= {1'b0, cell_d.s_dsh};
      if (h_ge) begin
         cell_in.h_rem = cell_d.h_rem - {1'b0, cell_d.h_dsh};
      end
      if (s_ge) begin
         cell_in.s_rem = cell_d.s_rem - {1'b0, cell_d.s_dsh};
      end
      cell_in.h_quo = {cell_d.h_quo[QUO_BITS-2:0], h_ge};
      cell_in.s_quo = {cell_d.s_quo[QUO_BITS-2:0], s_ge};
      cell_in.h_dsh = cell_d.h_dsh >> 1;
      cell_in.s_dsh = cell_d.s_dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;

endmodule
`default_nettype wire

// ===== rtl/rgbhsv_front.sv =====
// input stage: extremes, sector, span and division operands
`default_nettype none
module rgbhsv_front import rgbhsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req_data,
   output cell_type cell_q
);

   cell_type    cell_ff, cell_in;
   logic [7:0]  top, low, span;
   logic [1:0]  sector;
   logic [8:0]  diff;
   logic [7:0]  mag;

   always_comb begin
      top    = 8'd0;
      sector = SECT_NONE;
      if (req_data.red > top) begin
         top    = req_data.red;
         sector = SECT_RED;
      end
      if (req_data.green > top) begin
         top    = req_data.green;
         sector = SECT_GREEN;
      end
      if (req_data.blue > top) begin
         top    = req_data.blue;
         sector = SECT_BLUE;
      end
      low = req_data.red;
      if (req_data.green < low) low = req_data.green;
      if (req_data.blue < low) low = req_data.blue;
      span = top - low;
      case (sector)
         SECT_RED:   diff = {1'b0, req_data.green} - {1'b0, req_data.blue};
         SECT_GREEN: diff = {1'b0, req_data.blue} - {1'b0, req_data.red};
         SECT_BLUE:  diff = {1'b0, req_data.red} - {1'b0, req_data.green};
         default:    diff = 9'd0;
      endcase
      mag = diff[8] ? 8'(-diff) : diff[7:0];

      cell_in.valid    = start;
      cell_in.h_rem    = NUM_BITS'(mag) * NUM_BITS'(100);
      cell_in.h_dsh    = {span, 6'd0};
      cell_in.h_quo    = '0;
      cell_in.s_rem    = NUM_BITS'(span) * NUM_BITS'(100);
      cell_in.s_dsh    = {top, 6'd0};
      cell_in.s_quo    = '0;
      cell_in.neg      = diff[8];
      cell_in.sector   = sector;
      cell_in.hue_zero = span == 8'd0;
      cell_in.sat_zero = top == 8'd0;
      cell_in.top      = top;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;

endmodule
`default_nettype wire

// ===== rtl/rgbhsv_back.sv =====
// output stage: sector offset, degree scaling and percent value
`default_nettype none
module rgbhsv_back import rgbhsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_d,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   logic        valid_ff;
   rsp_type     data_ff, data_in;
   logic [9:0]  base, xval;
   logic [10:0] x3;
   logic [24:0] hprod;
   logic [29:0] vprod;

   always_comb begin
      case (cell_d.sector)
         SECT_GREEN: base = 10'd200;
         SECT_BLUE:  base = 10'd400;
         default:    base = (cell_d.neg && cell_d.h_quo != '0) ? 10'd600 : 10'd0;
      endcase
      if (cell_d.neg) begin
         xval = base - 10'(cell_d.h_quo);
      end else begin
         xval = base + 10'(cell_d.h_quo);
      end
      x3    = 11'(xval) + {xval, 1'b0};
      hprod = 25'(x3) * 25'd6554;
      vprod = 30'(cell_d.top) * 30'd3289700;
      data_in.hue        = cell_d.hue_zero ? 9'd0 : hprod[23:15];
      data_in.saturation = cell_d.sat_zero ? 7'd0 : cell_d.s_quo;
      data_in.brightness = vprod[29:23];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_d.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsv_integer_converter_top.sv =====
// Converts one 8-bit red, green, blue sample per cycle to hue in degrees,
// saturation and value in percent. busy is always low: an item can be
// started in every cycle. Its result is strobed on rsp_data with rsp_valid
// for one cycle. The pipeline is an input stage, a chain of seven divider
// cells that each settle one quotient bit of the hue and saturation
// divisions, and an output stage. The receiver cannot stall, so it must
// take every result as it is strobed.
`default_nettype none
module rgb_to_hsv_integer_converter_top import rgbhsv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cell_type chain [NUM_CELLS+1];

   assign busy = 1'b0;

   rgbhsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .cell_q   (chain[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      rgbhsv_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cell_d (chain[i]),
         .cell_q (chain[i+1])
      );
   end

   rgbhsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cell_d    (chain[NUM_CELLS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/rgbhsv_checker.sv =====
// port checker for the rgb to hsv converter and its bind
`default_nettype none
`include "assert_macros.svh"
module rgbhsv_checker import rgbhsv_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic in_range, grey_in, grey_out;

   assign in_range = rsp_data.hue < 9'd360 && rsp_data.saturation <= 7'd100
                     && rsp_data.brightness <= 7'd100;
   assign grey_in  = req_data.red == req_data.green && req_data.green == req_data.blue;
   assign grey_out = rsp_data.hue == 9'd0 && rsp_data.saturation == 7'd0;

   `ASSERT_IMPLIES(a_latency, clock, reset, start && !busy, ##9 rsp_valid)
   `ASSERT_IMPLIES(a_no_spurious, clock, reset, !$past(start && !busy, 9), !rsp_valid)
   `ASSERT_IMPLIES(a_range, clock, reset, rsp_valid, in_range)
   `ASSERT_IMPLIES(a_grey, clock, reset, start && !busy && grey_in, ##9 grey_out)

endmodule

bind rgb_to_hsv_integer_converter_top rgbhsv_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
